// ===== design/scpr_pkg.sv =====
package scpr_pkg;

	// Fixed field widths of the request and result items.
	localparam int PAGE_W      = 16;
	localparam int FRAME_IDX_W = 4;
	localparam int FAULT_W     = 16;
	localparam int CFG_W       = 5;

	// Defaults for the top-level parameters.
	localparam int FRAMES_DEF    = 16;
	localparam int PAGE_BITS_DEF = 16;

	// Configuration port.
	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam int REG_IDX_W  = 1;

	localparam logic [REG_IDX_W-1:0] REG_FRAMES_IN_USE = REG_IDX_W'(0);

endpackage

// ===== design/scpr_if.sv =====
interface scpr_req_if;
	logic                       valid;
	logic                       ready;
	logic [scpr_pkg::PAGE_W-1:0] page;

	modport source (output valid, output page, input ready);
	modport sink   (input valid, input page, output ready);
endinterface

interface scpr_res_if;
	logic                             valid;
	logic                             ready;
	logic                             hit;
	logic [scpr_pkg::FRAME_IDX_W-1:0] frame_index;
	logic                             evicted_valid;
	logic [scpr_pkg::PAGE_W-1:0]      evicted_page;
	logic [scpr_pkg::FAULT_W-1:0]     fault_total;

	modport source (
		output valid, output hit, output frame_index, output evicted_valid,
		output evicted_page, output fault_total, input ready
	);
	modport sink (
		input valid, input hit, input frame_index, input evicted_valid,
		input evicted_page, input fault_total, output ready
	);
endinterface

// ===== design/scpr_page_ram.sv =====
module scpr_page_ram #(
	parameter int DEPTH = scpr_pkg::FRAMES_DEF,
	parameter int WIDTH = scpr_pkg::PAGE_BITS_DEF,
	localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

// ===== design/scpr_apb_regs.sv =====
module scpr_apb_regs #(
	parameter int FRAMES = scpr_pkg::FRAMES_DEF,
	localparam int CW    = $clog2(FRAMES + 1)
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scpr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [scpr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [scpr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready,
	output logic [CW-1:0]                   active_frames
);

	logic [scpr_pkg::CFG_W-1:0]     frames_q;
	logic [scpr_pkg::REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[scpr_pkg::APB_ADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frames_q <= scpr_pkg::CFG_W'(FRAMES);
		end else if (psel && penable && pwrite && pready
				&& reg_idx == scpr_pkg::REG_FRAMES_IN_USE) begin
			frames_q <= pwdata[scpr_pkg::CFG_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == scpr_pkg::REG_FRAMES_IN_USE) begin
			prdata = scpr_pkg::APB_DATA_W'(frames_q);
		end
	end

	// A count of zero behaves as one frame; a count above the frame store is clipped.
	always_comb begin
		priority if (frames_q == '0) begin
			active_frames = CW'(1);
		end else if (32'(frames_q) > FRAMES) begin
			active_frames = CW'(FRAMES);
		end else begin
			active_frames = CW'(frames_q);
		end
	end

endmodule

// ===== design/second_chance_page_replacer_unit.sv =====
// Second-chance (clock) page replacer.
//
// Requests arrive on req (valid/ready, one page number each); every request
// gives exactly one result on res: hit flag, frame holding the page, the page
// that was evicted if any, and the saturating fault count including this one.
// frames_in_use is written over the APB port at byte address 0.
//
// One request is handled at a time. The page numbers live in a single-port
// read, single-port write memory with a registered read port, scanned one
// frame per cycle from frame 0 until a hit. A miss scans all n frames in use,
// then the clock hand sweeps one frame per cycle over the s referenced frames
// it clears, then ST_EVICT writes the victim and ST_DONE loads the result once
// the output register is free. The next request can be taken in the cycle
// after the result is loaded.
//
// Reset marks every frame empty and unreferenced, puts the hand at frame 0,
// clears the fault count and sets frames_in_use to FRAMES. The finished result
// sits in an output register; while res is stalled the next request is
// already taken and worked on, and it waits only for that register to empty.
module second_chance_page_replacer_unit #(
	parameter int FRAMES    = scpr_pkg::FRAMES_DEF,
	parameter int PAGE_BITS = scpr_pkg::PAGE_BITS_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	scpr_req_if.sink                        req,
	scpr_res_if.source                      res,
	input  logic                            psel,
	input  logic                            penable,
	input  logic                            pwrite,
	input  logic [scpr_pkg::APB_ADDR_W-1:0] paddr,
	input  logic [scpr_pkg::APB_DATA_W-1:0] pwdata,
	output logic [scpr_pkg::APB_DATA_W-1:0] prdata,
	output logic                            pready
);

	localparam int IW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int CW = $clog2(FRAMES + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOK,
		ST_SWEEP,
		ST_EVICT,
		ST_DONE
	} state_t;

	state_t                        state_q;
	logic [PAGE_BITS-1:0]          pg_q;
	logic [CW-1:0]                 n_q;
	logic [CW-1:0]                 idx_q;
	logic                          chk_vld_s1;
	logic [IW-1:0]                 chk_idx_s1;
	logic [IW-1:0]                 hand_q;
	logic [FRAMES-1:0]             valid_q;
	logic [FRAMES-1:0]             refd_q;
	logic [scpr_pkg::FAULT_W-1:0]  fault_q;

	logic                          res_hit_q;
	logic [IW-1:0]                 res_frame_q;
	logic                          res_ev_vld_q;
	logic [PAGE_BITS-1:0]          res_ev_page_q;
	logic [scpr_pkg::FAULT_W-1:0]  res_fault_q;

	logic                              out_vld_q;
	logic                              out_hit_q;
	logic [scpr_pkg::FRAME_IDX_W-1:0]  out_frame_q;
	logic                              out_ev_vld_q;
	logic [scpr_pkg::PAGE_W-1:0]       out_ev_page_q;
	logic [scpr_pkg::FAULT_W-1:0]      out_fault_q;

	logic [CW-1:0]                 active_frames;
	logic [PAGE_BITS-1:0]          rd_data;
	logic [IW-1:0]                 raddr;
	logic                          we;
	logic                          match;
	logic                          last_chk;
	logic [IW-1:0]                 hand_start;
	logic [IW-1:0]                 hand_next;
	logic [scpr_pkg::FAULT_W-1:0]  fault_next;
	logic                          out_free;

	scpr_apb_regs #(.FRAMES(FRAMES)) u_regs (
		.clk           (clk),
		.arst_n        (arst_n),
		.psel          (psel),
		.penable       (penable),
		.pwrite        (pwrite),
		.paddr         (paddr),
		.pwdata        (pwdata),
		.prdata        (prdata),
		.pready        (pready),
		.active_frames (active_frames)
	);

	// Each request finishes its write-back before the next one is taken, so
	// the scan never sees a stale entry.
	scpr_page_ram #(.DEPTH(FRAMES), .WIDTH(PAGE_BITS)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (hand_q),
		.wdata (pg_q),
		.raddr (raddr),
		.rdata (rd_data)
	);

	assign raddr    = (state_q == ST_LOOK) ? idx_q[IW-1:0] : hand_q;
	assign we       = (state_q == ST_EVICT);
	assign match    = chk_vld_s1 && valid_q[chk_idx_s1] && rd_data == pg_q;
	assign last_chk = CW'(chk_idx_s1) == n_q - CW'(1);

	// A hand left beyond a lowered frame count restarts at frame 0.
	assign hand_start = (CW'(hand_q) >= n_q) ? '0 : hand_q;
	assign hand_next  = (CW'(hand_q) + CW'(1) == n_q) ? '0 : hand_q + IW'(1);
	assign fault_next = (fault_q == '1) ? fault_q : fault_q + scpr_pkg::FAULT_W'(1);
	assign out_free   = !out_vld_q || res.ready;

	assign req.ready         = (state_q == ST_IDLE);
	assign res.valid         = out_vld_q;
	assign res.hit           = out_hit_q;
	assign res.frame_index   = out_frame_q;
	assign res.evicted_valid = out_ev_vld_q;
	assign res.evicted_page  = out_ev_page_q;
	assign res.fault_total   = out_fault_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			pg_q          <= '0;
			n_q           <= '0;
			idx_q         <= '0;
			chk_vld_s1    <= 1'b0;
			chk_idx_s1    <= '0;
			hand_q        <= '0;
			valid_q       <= '0;
			refd_q        <= '0;
			fault_q       <= '0;
			res_hit_q     <= 1'b0;
			res_frame_q   <= '0;
			res_ev_vld_q  <= 1'b0;
			res_ev_page_q <= '0;
			res_fault_q   <= '0;
			out_vld_q     <= 1'b0;
			out_hit_q     <= 1'b0;
			out_frame_q   <= '0;
			out_ev_vld_q  <= 1'b0;
			out_ev_page_q <= '0;
			out_fault_q   <= '0;
		end else begin
			// In ST_DONE the output register is reloaded below instead.
			if (out_vld_q && res.ready && state_q != ST_DONE) begin
				out_vld_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (req.valid) begin
						pg_q       <= PAGE_BITS'(req.page);
						n_q        <= active_frames;
						idx_q      <= '0;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_LOOK;
					end
				end
				ST_LOOK: begin
					// Frames are compared in order, so the first match is the lowest.
					priority if (match) begin
						refd_q[chk_idx_s1] <= 1'b1;
						res_hit_q     <= 1'b1;
						res_frame_q   <= chk_idx_s1;
						res_ev_vld_q  <= 1'b0;
						res_ev_page_q <= '0;
						res_fault_q   <= fault_q;
						chk_vld_s1    <= 1'b0;
						state_q       <= ST_DONE;
					end else if (chk_vld_s1 && last_chk) begin
						hand_q     <= hand_start;
						chk_vld_s1 <= 1'b0;
						state_q    <= ST_SWEEP;
					end else begin
						chk_vld_s1 <= idx_q < n_q;
						chk_idx_s1 <= idx_q[IW-1:0];
						if (idx_q < n_q) begin
							idx_q <= idx_q + CW'(1);
						end
					end
				end
				ST_SWEEP: begin
					// The frame where the hand stops is read this cycle.
					if (refd_q[hand_q]) begin
						refd_q[hand_q] <= 1'b0;
						hand_q         <= hand_next;
					end else begin
						state_q <= ST_EVICT;
					end
				end
				ST_EVICT: begin
					res_hit_q     <= 1'b0;
					res_frame_q   <= hand_q;
					res_ev_vld_q  <= valid_q[hand_q];
					res_ev_page_q <= valid_q[hand_q] ? rd_data : '0;
					res_fault_q   <= fault_next;
					valid_q[hand_q] <= 1'b1;
					refd_q[hand_q]  <= 1'b0;
					hand_q          <= hand_next;
					fault_q         <= fault_next;
					state_q         <= ST_DONE;
				end
				ST_DONE: begin
					if (out_free) begin
						out_vld_q     <= 1'b1;
						out_hit_q     <= res_hit_q;
						out_frame_q   <= scpr_pkg::FRAME_IDX_W'(res_frame_q);
						out_ev_vld_q  <= res_ev_vld_q;
						out_ev_page_q <= scpr_pkg::PAGE_W'(res_ev_page_q);
						out_fault_q   <= res_fault_q;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== design/scpr_checker.sv =====
module scpr_checker (
	input logic                            clk,
	input logic                            arst_n,
	input logic                            req_valid,
	input logic                            req_ready,
	input logic                            res_valid,
	input logic                            res_ready,
	input logic                            res_hit,
	input logic                            res_evicted_valid,
	input logic [scpr_pkg::FAULT_W-1:0]    res_fault_total
);

	// A stalled result keeps its valid and its fault count.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_fault_total))
		else $error("result dropped or changed while stalled");

	// Requests are handled one at a time.
	assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready)
		else $error("second request taken while one is in flight");

	// A hit never evicts anything.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_hit |-> !res_evicted_valid)
		else $error("eviction reported on a hit");

	// A fault has always been counted by the time it is reported.
	assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_hit |-> res_fault_total != '0)
		else $error("fault reported with a zero fault count");

endmodule

bind second_chance_page_replacer_unit scpr_checker u_scpr_checker (
	.clk               (clk),
	.arst_n            (arst_n),
	.req_valid         (req.valid),
	.req_ready         (req.ready),
	.res_valid         (res.valid),
	.res_ready         (res.ready),
	.res_hit           (res.hit),
	.res_evicted_valid (res.evicted_valid),
	.res_fault_total   (res.fault_total)
);
